[design/fbr_pkg.sv]
// Package for the page framebuffer line and circle raster engine.
// Holds command kinds, panel geometry, controller state and the
// command/status structs; no dependencies.
`timescale 1ns / 1ps

package fbr_pkg;

  // Command kinds carried in the input tuser
  typedef enum logic [1:0] {
    KIND_PLOT   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_CIRCLE = 2'd2,
    KIND_READ   = 2'd3
  } fbr_kind_e;

  // Panel geometry: wide (mode 0) and tall (mode 1) layouts
  localparam int PANEL_W_WIDE = 132;
  localparam int PANEL_H_WIDE = 32;
  localparam int PANEL_W_TALL = 128;
  localparam int PANEL_H_TALL = 64;

  // Framebuffer byte index and read address widths
  localparam int IDX_W       = 10;
  localparam int BYTE_ADDR_W = 10;
  localparam int PIXEL_W     = 8;

  // Configuration register indexes (paddr[2])
  localparam logic REG_PANEL_MODE = 1'b0;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } fbr_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;       // write zero at the clear counter and advance it
    logic load;      // capture a new command and set up the steppers
    logic wr;        // write back the modified byte or capture read data
    logic step;      // advance the line or circle stepper
    logic load_out;  // move the result into the output register
  } fbr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    fbr_kind_e kind;
    logic      clr_last;   // clear counter at the last byte
    logic      line_last;  // line at its end point
    logic      circ_last;  // circle step leaves x non-negative
    logic      sub_last;   // fourth octant pixel of a circle step
  } fbr_status_t;

endpackage

[design/fbr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/fbr_datapath.sv]
// Datapath of the raster engine: line and circle steppers, clipping and
// byte index, read-modify-write of the framebuffer, result registers.
// Depends on fbr_pkg and fbr_ram.
`timescale 1ns / 1ps

module fbr_datapath #(
  parameter int STORE_BYTES = 1024,
  parameter int COORD_BITS  = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fbr_pkg::fbr_cmd_t                   cmd_i,
  output fbr_pkg::fbr_status_t                status_o,
  input  logic                                panel_mode_i,
  input  logic [1:0]                          kind_i,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  input  logic [COORD_BITS-2:0]               radius_i,
  input  logic                                pixel_on_i,
  input  logic [fbr_pkg::BYTE_ADDR_W-1:0]     byte_address_i,
  output logic [fbr_pkg::PIXEL_W-1:0]         read_byte_o
);

  localparam int CB  = COORD_BITS;
  localparam int PW  = COORD_BITS + 1;  // line deltas, circle offsets
  localparam int QW  = COORD_BITS + 2;  // pixel coordinates before clipping
  localparam int EW  = COORD_BITS + 4;  // error terms
  localparam int EW1 = EW + 1;
  localparam int AW  = $clog2(STORE_BYTES);

  localparam logic signed [CB-1:0] C_ONE = CB'(1);
  localparam logic signed [EW-1:0] E_ONE = EW'(1);
  localparam logic signed [EW-1:0] E_TWO = EW'(2);

  // Command registers
  fbr_pkg::fbr_kind_e kind_q, kind_d;
  logic                         on_q, on_d;
  logic [fbr_pkg::BYTE_ADDR_W-1:0] addr_q, addr_d;

  // Line stepper registers (also hold the plot coordinate)
  logic signed [CB-1:0] lx_q, lx_d, ly_q, ly_d, lx1_q, lx1_d, ly1_q, ly1_d;
  logic signed [PW-1:0] ldx_q, ldx_d, ldy_q, ldy_d;
  logic                 lsx_q, lsx_d, lsy_q, lsy_d;
  logic signed [EW-1:0] lerr_q, lerr_d;

  // Circle stepper registers
  logic signed [CB-1:0] ccx_q, ccx_d, ccy_q, ccy_d;
  logic signed [PW-1:0] cxv_q, cxv_d, cyv_q, cyv_d;
  logic signed [EW-1:0] cerr_q, cerr_d;
  logic [1:0]           sub_q, sub_d;

  // Clear counter and result registers
  logic [AW-1:0]                  clr_cnt_q, clr_cnt_d;
  logic [fbr_pkg::PIXEL_W-1:0]    result_q, result_d;
  logic [fbr_pkg::PIXEL_W-1:0]    out_byte_q, out_byte_d;

  // Line setup from the new command
  logic signed [PW-1:0] sx_w, sy_w, ex_w, ey_w, ddx, ddy, adx, ndy;
  // Line step
  logic signed [EW1-1:0] le2;
  logic                  step_x, step_y;
  logic signed [EW-1:0]  lerr_n;
  logic signed [CB-1:0]  lx_n, ly_n;
  logic                  line_last;
  // Circle step
  logic signed [EW-1:0]  cx_e, cy_e, cx1, cy1, cerr1, cerr2;
  logic                  inc_x, inc_y, circ_last;
  // Pixel target and clipping
  logic signed [QW-1:0]  px, py;
  logic [QW-1:0]         w_lim, h_lim;
  logic                  on_panel, pix_ok, rd_ok, set_px;
  logic [2:0]            page;
  logic [fbr_pkg::IDX_W-1:0] idx;
  logic [fbr_pkg::PIXEL_W-1:0] bit_mask, mod_byte, rdata;
  // RAM ports
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [fbr_pkg::PIXEL_W-1:0] wdata;

  // Set up line deltas and directions
  always_comb begin
    sx_w = PW'(start_x_i);
    sy_w = PW'(start_y_i);
    ex_w = PW'(end_x_i);
    ey_w = PW'(end_y_i);
    ddx  = ex_w - sx_w;
    ddy  = ey_w - sy_w;
    adx  = ddx[PW-1] ? -ddx : ddx;
    ndy  = ddy[PW-1] ? ddy : -ddy;
  end

  // Advance the line by one Bresenham step
  always_comb begin
    le2       = {lerr_q, 1'b0};
    step_x    = le2 > EW1'(ldy_q);
    step_y    = le2 < EW1'(ldx_q);
    lerr_n    = lerr_q + (step_x ? EW'(ldy_q) : '0) + (step_y ? EW'(ldx_q) : '0);
    lx_n      = step_x ? (lsx_q ? lx_q + C_ONE : lx_q - C_ONE) : lx_q;
    ly_n      = step_y ? (lsy_q ? ly_q + C_ONE : ly_q - C_ONE) : ly_q;
    line_last = (lx_q == lx1_q) && (ly_q == ly1_q);
  end

  // Advance the circle by one midpoint step; y first, then x
  always_comb begin
    cx_e      = EW'(cxv_q);
    cy_e      = EW'(cyv_q);
    inc_y     = cerr_q <= cy_e;
    cy1       = inc_y ? cy_e + E_ONE : cy_e;
    cerr1     = inc_y ? cerr_q + (cy1 <<< 1) + E_ONE : cerr_q;
    inc_x     = (cerr_q > cx_e) || (cerr1 > cy1);
    cx1       = inc_x ? cx_e + E_ONE : cx_e;
    cerr2     = inc_x ? cerr1 + (cx1 <<< 1) + E_ONE : cerr1;
    circ_last = !cx1[EW-1];
  end

  // Select the pixel of this read-modify-write
  always_comb begin
    px = QW'(lx_q);
    py = QW'(ly_q);
    if (kind_q == fbr_pkg::KIND_CIRCLE) begin
      case (sub_q)
        2'd0: begin
          px = QW'(ccx_q) + QW'(cyv_q);
          py = QW'(ccy_q) + QW'(cxv_q);
        end
        2'd1: begin
          px = QW'(ccx_q) - QW'(cxv_q);
          py = QW'(ccy_q) + QW'(cyv_q);
        end
        2'd2: begin
          px = QW'(ccx_q) - QW'(cyv_q);
          py = QW'(ccy_q) - QW'(cxv_q);
        end
        default: begin
          px = QW'(ccx_q) + QW'(cxv_q);
          py = QW'(ccy_q) - QW'(cyv_q);
        end
      endcase
    end
  end

  // Clip to the panel and form the page-organized byte index
  always_comb begin
    w_lim    = panel_mode_i ? QW'(fbr_pkg::PANEL_W_TALL) : QW'(fbr_pkg::PANEL_W_WIDE);
    h_lim    = panel_mode_i ? QW'(fbr_pkg::PANEL_H_TALL) : QW'(fbr_pkg::PANEL_H_WIDE);
    on_panel = !px[QW-1] && !py[QW-1] && ($unsigned(px) < w_lim) && ($unsigned(py) < h_lim);
    page     = py[5:3];
    idx      = fbr_pkg::IDX_W'(px[7:0])
             + (panel_mode_i ? {page, 7'd0} : ({page, 7'd0} + {5'd0, page, 2'd0}));
    pix_ok   = on_panel && (32'(idx) < 32'(STORE_BYTES));
    rd_ok    = 32'(addr_q) < 32'(STORE_BYTES);
    bit_mask = fbr_pkg::PIXEL_W'(1) << py[2:0];
    set_px   = (kind_q == fbr_pkg::KIND_PLOT) ? on_q : 1'b1;
    mod_byte = set_px ? (rdata | bit_mask) : (rdata & ~bit_mask);
  end

  // Drive the framebuffer ports
  always_comb begin
    raddr = (kind_q == fbr_pkg::KIND_READ) ? AW'(addr_q) : AW'(idx);
    we    = cmd_i.clr || (cmd_i.wr && pix_ok && (kind_q != fbr_pkg::KIND_READ));
    waddr = cmd_i.clr ? clr_cnt_q : AW'(idx);
    wdata = cmd_i.clr ? '0 : mod_byte;
  end

  fbr_ram #(
    .WIDTH (fbr_pkg::PIXEL_W),
    .DEPTH (STORE_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Next state of all datapath registers
  always_comb begin
    kind_d     = kind_q;
    on_d       = on_q;
    addr_d     = addr_q;
    lx_d       = lx_q;
    ly_d       = ly_q;
    lx1_d      = lx1_q;
    ly1_d      = ly1_q;
    ldx_d      = ldx_q;
    ldy_d      = ldy_q;
    lsx_d      = lsx_q;
    lsy_d      = lsy_q;
    lerr_d     = lerr_q;
    ccx_d      = ccx_q;
    ccy_d      = ccy_q;
    cxv_d      = cxv_q;
    cyv_d      = cyv_q;
    cerr_d     = cerr_q;
    sub_d      = sub_q;
    clr_cnt_d  = clr_cnt_q;
    result_d   = result_q;
    out_byte_d = out_byte_q;

    // Advance the clearing pass
    if (cmd_i.clr) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
    end

    // Capture a new command and set up both steppers
    if (cmd_i.load) begin
      kind_d   = fbr_pkg::fbr_kind_e'(kind_i);
      on_d     = pixel_on_i;
      addr_d   = byte_address_i;
      lx_d     = start_x_i;
      ly_d     = start_y_i;
      lx1_d    = end_x_i;
      ly1_d    = end_y_i;
      ldx_d    = adx;
      ldy_d    = ndy;
      lsx_d    = start_x_i < end_x_i;
      lsy_d    = start_y_i < end_y_i;
      lerr_d   = EW'(adx) + EW'(ndy);
      ccx_d    = start_x_i;
      ccy_d    = start_y_i;
      cxv_d    = -PW'($signed({1'b0, radius_i}));
      cyv_d    = '0;
      cerr_d   = E_TWO - (EW'($signed({1'b0, radius_i})) <<< 1);
      sub_d    = 2'd0;
      result_d = '0;
    end

    // Capture the addressed byte of a read command
    if (cmd_i.wr && (kind_q == fbr_pkg::KIND_READ)) begin
      result_d = rd_ok ? rdata : '0;
    end

    // Advance the active stepper
    if (cmd_i.step) begin
      if (kind_q == fbr_pkg::KIND_LINE) begin
        lx_d   = lx_n;
        ly_d   = ly_n;
        lerr_d = lerr_n;
      end else if (kind_q == fbr_pkg::KIND_CIRCLE) begin
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          cxv_d  = PW'(cx1);
          cyv_d  = PW'(cy1);
          cerr_d = cerr2;
        end
      end
    end

    // Hand the result to the output register
    if (cmd_i.load_out) begin
      out_byte_d = result_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= fbr_pkg::KIND_PLOT;
      sub_q     <= 2'd0;
      clr_cnt_q <= '0;
    end else begin
      kind_q    <= kind_d;
      sub_q     <= sub_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    on_q       <= on_d;
    addr_q     <= addr_d;
    lx_q       <= lx_d;
    ly_q       <= ly_d;
    lx1_q      <= lx1_d;
    ly1_q      <= ly1_d;
    ldx_q      <= ldx_d;
    ldy_q      <= ldy_d;
    lsx_q      <= lsx_d;
    lsy_q      <= lsy_d;
    lerr_q     <= lerr_d;
    ccx_q      <= ccx_d;
    ccy_q      <= ccy_d;
    cxv_q      <= cxv_d;
    cyv_q      <= cyv_d;
    cerr_q     <= cerr_d;
    result_q   <= result_d;
    out_byte_q <= out_byte_d;
  end

  // Report status
  always_comb begin
    status_o.kind      = kind_q;
    status_o.clr_last  = clr_cnt_q == AW'(STORE_BYTES - 1);
    status_o.line_last = line_last;
    status_o.circ_last = circ_last;
    status_o.sub_last  = sub_q == 2'd3;
  end

  assign read_byte_o = out_byte_q;

endmodule

[design/fbr_ctrl.sv]
// Controller of the raster engine: clearing pass, command sequencing,
// read-modify-write timing and output handshake.
// Depends on fbr_pkg.
`timescale 1ns / 1ps

module fbr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  fbr_pkg::fbr_status_t status_i,
  output fbr_pkg::fbr_cmd_t    cmd_o
);

  fbr_pkg::fbr_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // Sequence one command through read and write cycles
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    // Drop the result once the receiver takes it
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      fbr_pkg::S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = fbr_pkg::S_IDLE;
        end
      end
      fbr_pkg::S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fbr_pkg::S_READ;
        end
      end
      fbr_pkg::S_READ: begin
        state_d = fbr_pkg::S_WRITE;
      end
      fbr_pkg::S_WRITE: begin
        cmd_o.wr = 1'b1;
        case (status_i.kind)
          fbr_pkg::KIND_LINE: begin
            if (status_i.line_last) begin
              state_d = fbr_pkg::S_DONE;
            end else begin
              cmd_o.step = 1'b1;
              state_d    = fbr_pkg::S_READ;
            end
          end
          fbr_pkg::KIND_CIRCLE: begin
            cmd_o.step = 1'b1;
            if (status_i.sub_last && status_i.circ_last) begin
              state_d = fbr_pkg::S_DONE;
            end else begin
              state_d = fbr_pkg::S_READ;
            end
          end
          default: begin
            state_d = fbr_pkg::S_DONE;
          end
        endcase
      end
      fbr_pkg::S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = fbr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fbr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbr_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = state_q == fbr_pkg::S_IDLE;
  assign m_tvalid_o = out_valid_q;

endmodule

[design/page_framebuffer_line_circle_raster.sv]
// Page framebuffer engine: draws pixels, lines and circles and reads bytes.
// The input stream carries one command per transaction, the kind in tuser;
// the output stream returns one byte per command (zero for drawing kinds).
// panel_mode selects 132x32 (0) or 128x64 (1) on the APB port.
//
// After reset a clearing pass zeroes the framebuffer one byte per cycle,
// all STORE_BYTES bytes, with s_axis_tready low; APB writes are taken as ever.
// Each pixel is a read-modify-write of one byte through the RAM's
// registered read port, in a read state then a write state. A plot or a
// byte read passes once through read and write, a line of N pixels once
// per pixel, and a circle once per octant pixel, four per midpoint step;
// then a done state loads the result and raises m_axis_tvalid. The block
// takes the next command in the cycle after a result is loaded.
// If the receiver stalls, the result waits in the output register while
// the next command is accepted and drawn; that command's result is held
// back until the register is taken. Off-panel pixels are skipped silently.
// Depends on fbr_pkg, fbr_ctrl, fbr_datapath and fbr_ram.
`timescale 1ns / 1ps

module page_framebuffer_line_circle_raster #(
  parameter int STORE_BYTES = 1024,
  parameter int COORD_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: start_x, start_y, end_x, end_y, radius, pixel_on,
  // byte_address, zero fill
  input  logic [((5*COORD_BITS+10+7)/8)*8-1:0] s_axis_tdata,
  // fields from bit 0: kind
  input  logic [1:0]  s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fields from bit 0: read_byte
  output logic [7:0]  m_axis_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB = COORD_BITS;

  fbr_pkg::fbr_cmd_t    cmd;
  fbr_pkg::fbr_status_t status;
  logic                 panel_mode_q;
  logic                 cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == fbr_pkg::REG_PANEL_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_mode_q <= 1'b1;
    end else if (cfg_wr) begin
      panel_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == fbr_pkg::REG_PANEL_MODE) ? {31'd0, panel_mode_q} : 32'd0;

  fbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fbr_datapath #(
    .STORE_BYTES (STORE_BYTES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .panel_mode_i   (panel_mode_q),
    .kind_i         (s_axis_tuser),
    .start_x_i      (s_axis_tdata[CB-1:0]),
    .start_y_i      (s_axis_tdata[2*CB-1:CB]),
    .end_x_i        (s_axis_tdata[3*CB-1:2*CB]),
    .end_y_i        (s_axis_tdata[4*CB-1:3*CB]),
    .radius_i       (s_axis_tdata[5*CB-2:4*CB]),
    .pixel_on_i     (s_axis_tdata[5*CB-1]),
    .byte_address_i (s_axis_tdata[5*CB+9:5*CB]),
    .read_byte_o    (m_axis_tdata)
  );

  // Drawing commands always return a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out && (status.kind != fbr_pkg::KIND_READ) |=> m_axis_tdata == 8'd0)
    else $error("drawing command returned a nonzero byte");

  // Never overwrite a result the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while stalled");

  // No command is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !s_axis_tready && !cmd.load)
    else $error("command accepted during clearing pass");

endmodule

[tb/testbench.sv]
// Self-checking bench for the page framebuffer raster engine: directed table, then random
// commands over both panel layouts, results checked against table values or a local framebuffer model.
// Depends on fbr_pkg and page_framebuffer_line_circle_raster.
`timescale 1ns / 1ps

module testbench;

  localparam int STORE_BYTES   = 1024;
  localparam int COORD_BITS    = 12;
  localparam int DATA_W        = ((5*COORD_BITS+10+7)/8)*8;
  localparam int ITEMS_PER_RUN = 150;
  localparam int HOLD_AT       = 260;
  localparam int HOLD_CYCLES   = 1500;
  localparam int DRAIN_CYCLES  = 60;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int REPORT_MAX    = 10;

  typedef enum logic {ROW_CMD, ROW_MODE} row_op_e;

  typedef struct {
    row_op_e            op;
    fbr_pkg::fbr_kind_e kind;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic signed [11:0] ex;
    logic signed [11:0] ey;
    logic [10:0]        radius;
    logic               pix_on;
    logic [9:0]         addr;
    bit                 typed;
    logic [7:0]         want;
  } draw_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // fields from bit 0: start_x, start_y, end_x, end_y, radius, pixel_on, byte_address, zero fill
  logic [DATA_W-1:0] s_axis_tdata;
  // fields from bit 0: kind
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // fields from bit 0: read_byte
  logic [7:0]        m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Local framebuffer model and expected read bytes
  logic [7:0]  fb_model [STORE_BYTES];
  logic        model_mode;
  logic [7:0]  pending_bytes [$];
  draw_row_t   directed_rows [$];
  int          fail_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;

  page_framebuffer_line_circle_raster #(
    .STORE_BYTES(STORE_BYTES),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock, 10 ns period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Log a failure, print only the first few
  task automatic note_failure(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // Set or clear one pixel, dropping anything off the panel or past the store
  function automatic void fb_set_pixel(int x, int y, bit on);
    int w;
    int h;
    int idx;
    w = model_mode ? fbr_pkg::PANEL_W_TALL : fbr_pkg::PANEL_W_WIDE;
    h = model_mode ? fbr_pkg::PANEL_H_TALL : fbr_pkg::PANEL_H_WIDE;
    if (x < 0 || y < 0 || x >= w || y >= h) return;
    idx = x + (y / 8) * w;
    if (idx >= STORE_BYTES) return;
    if (on) fb_model[idx][y % 8] = 1'b1;
    else fb_model[idx][y % 8] = 1'b0;
  endfunction

  // Bresenham line, both end points included
  function automatic void fb_draw_line(int x0, int y0, int x1, int y1);
    int dx;
    int dy;
    int stx;
    int sty;
    int err;
    int e2;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
    stx = (x0 < x1) ? 1 : -1;
    sty = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    while (1) begin
      fb_set_pixel(x0, y0, 1'b1);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > dy) begin
        err += dy;
        x0  += stx;
      end
      if (e2 < dx) begin
        err += dx;
        y0  += sty;
      end
    end
  endfunction

  // Midpoint circle, four octant pixels per step
  function automatic void fb_draw_circle(int cx, int cy, int r);
    int x;
    int y;
    int err;
    int prev;
    x   = -r;
    y   = 0;
    err = 2 - 2 * r;
    do begin
      fb_set_pixel(cx + y, cy + x, 1'b1);
      fb_set_pixel(cx - x, cy + y, 1'b1);
      fb_set_pixel(cx - y, cy - x, 1'b1);
      fb_set_pixel(cx + x, cy - y, 1'b1);
      prev = err;
      if (prev <= y) begin
        y++;
        err += y * 2 + 1;
      end
      if (prev > x || err > y) begin
        x++;
        err += x * 2 + 1;
      end
    end while (x < 0);
  endfunction

  // Apply one command to the model and return its result byte
  function automatic logic [7:0] fb_apply(draw_row_t c);
    logic [7:0] res;
    res = 8'h00;
    case (c.kind)
      fbr_pkg::KIND_PLOT:   fb_set_pixel(c.sx, c.sy, c.pix_on);
      fbr_pkg::KIND_LINE:   fb_draw_line(c.sx, c.sy, c.ex, c.ey);
      fbr_pkg::KIND_CIRCLE: fb_draw_circle(c.sx, c.sy, int'(c.radius));
      default: begin
        if (int'(c.addr) < STORE_BYTES) res = fb_model[c.addr];
      end
    endcase
    return res;
  endfunction

  // Table entries
  function automatic void add_cmd(fbr_pkg::fbr_kind_e kind, int sx, int sy, int ex, int ey,
                                  int r, bit on, int addr, bit typed, logic [7:0] want);
    draw_row_t c;
    c.op     = ROW_CMD;
    c.kind   = kind;
    c.sx     = 12'(sx);
    c.sy     = 12'(sy);
    c.ex     = 12'(ex);
    c.ey     = 12'(ey);
    c.radius = 11'(r);
    c.pix_on = on;
    c.addr   = 10'(addr);
    c.typed  = typed;
    c.want   = want;
    directed_rows.push_back(c);
  endfunction

  function automatic void add_mode(bit mode);
    draw_row_t c;
    c.op     = ROW_MODE;
    c.kind   = fbr_pkg::KIND_PLOT;
    c.sx     = '0;
    c.sy     = '0;
    c.ex     = '0;
    c.ey     = '0;
    c.radius = '0;
    c.pix_on = 1'b0;
    c.addr   = 10'(mode);
    c.typed  = 1'b0;
    c.want   = 8'h00;
    directed_rows.push_back(c);
  endfunction

  // Coordinate near the panel, now and then anywhere in the field range
  function automatic logic signed [11:0] near_coord(int lo, int hi);
    if ($urandom_range(0, 19) == 0) return 12'($urandom());
    return 12'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  // Random command; ignored fields carry random bits too
  function automatic draw_row_t random_command();
    draw_row_t c;
    int pick;
    c.op     = ROW_CMD;
    c.typed  = 1'b0;
    c.want   = 8'h00;
    c.sx     = 12'($urandom());
    c.sy     = 12'($urandom());
    c.ex     = 12'($urandom());
    c.ey     = 12'($urandom());
    c.radius = 11'($urandom());
    c.pix_on = 1'($urandom());
    c.addr   = 10'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.kind   = fbr_pkg::KIND_PLOT;
      c.sx     = near_coord(-8, 139);
      c.sy     = near_coord(-8, 71);
      c.pix_on = ($urandom_range(0, 4) > 1);
    end else if (pick < 55) begin
      c.kind = fbr_pkg::KIND_LINE;
      c.sx   = near_coord(-16, 147);
      c.sy   = near_coord(-16, 79);
      c.ex   = near_coord(-16, 147);
      c.ey   = near_coord(-16, 79);
    end else if (pick < 75) begin
      c.kind   = fbr_pkg::KIND_CIRCLE;
      c.sx     = near_coord(-16, 147);
      c.sy     = near_coord(-16, 79);
      c.radius = ($urandom_range(0, 99) < 3) ? 11'($urandom_range(0, 2047))
                                             : 11'($urandom_range(0, 40));
    end else begin
      c.kind = fbr_pkg::KIND_READ;
      if ($urandom_range(0, 9) < 7)
        c.addr = 10'($urandom_range(0, model_mode ? 1023 : 527));
    end
    return c;
  endfunction

  // APB write then read back
  task automatic set_panel_mode(bit mode);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = {fbr_pkg::REG_PANEL_MODE, 2'b00};
    pwdata  = {31'd0, mode};
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    model_mode = mode;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, mode}) note_failure("panel_mode readback", {31'd0, mode}, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Offer one command after a random gap; predict its result on acceptance
  bit send_busy = 1'b1;
  task automatic send_command(draw_row_t c);
    int gap;
    logic [7:0] predicted;
    if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
    gap = send_busy ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.kind;
    s_axis_tdata  = {2'b00, c.addr, c.pix_on, c.radius, c.ey, c.ex, c.sy, c.sx};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = fb_apply(c);
    pending_bytes.push_back(c.typed ? c.want : predicted);
    @(negedge clk_i);
    // Withdraw the offer until the next command is ready
    s_axis_tvalid = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off, compare with oldest expectation
  initial begin : result_sink
    bit busy;
    int stall;
    int i;
    logic [7:0] want;
    busy = 1'b1;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (results_seen == HOLD_AT) begin
        m_axis_tready = 1'b0;
        for (i = 0; i < HOLD_CYCLES; i++) @(negedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) busy = !busy;
      stall = busy ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      if (pending_bytes.size() == 0) begin
        note_failure("unexpected result, read_byte", 32'h0, {24'd0, m_axis_tdata});
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want) note_failure("read_byte", {24'd0, want},
                                               {24'd0, m_axis_tdata});
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    int i;
    int phase;
    bit phase_modes [4];
    model_mode    = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = fbr_pkg::KIND_PLOT;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (i = 0; i < STORE_BYTES; i++) fb_model[i] = 8'h00;
    phase_modes = '{1'b1, 1'b0, 1'b1, 1'b0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, tall layout first
    add_mode(1'b1);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,      -1,    -1,    -1,    -1, 2047, 1, 1023, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,       0,     0,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,    0, 1, 8'h01);
    add_cmd(fbr_pkg::KIND_PLOT,     127,    63,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0, 1023, 1, 8'h80);
    // Off-panel plots are dropped
    add_cmd(fbr_pkg::KIND_PLOT,      -1,     5,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,     128,     5,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,       5,    64,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,   -2048, -2048,  2047,  2047, 2047, 1, 1023, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,    2047,  2047, -2048, -2048,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  128, 1, 8'h00);
    // Clear a pixel
    add_cmd(fbr_pkg::KIND_PLOT,       0,     0,     0,     0,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_LINE,       0,     0,   127,    63,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_LINE,   -2048,  2047,  2047, -2048,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  700, 0, 8'h00);
    // Zero radius sets the centre only
    add_cmd(fbr_pkg::KIND_CIRCLE,    10,    10,     0,     0,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  138, 1, 8'h04);
    add_cmd(fbr_pkg::KIND_CIRCLE,    64,    32,     0,     0, 2047, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_CIRCLE,    64,    32,     0,     0,   20, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  556, 0, 8'h00);
    // Wide layout keeps the store as it is
    add_mode(1'b0);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0, 1023, 1, 8'h80);
    add_cmd(fbr_pkg::KIND_PLOT,     131,    31,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  527, 0, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,     132,     0,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_PLOT,       5,    32,     0,     0,    0, 1,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  132, 0, 8'h00);
    add_cmd(fbr_pkg::KIND_LINE,       0,    31,   131,     0,    0, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_CIRCLE,    66,    16,     0,     0,   15, 0,    0, 1, 8'h00);
    add_cmd(fbr_pkg::KIND_READ,       0,     0,     0,     0,    0, 0,  330, 0, 8'h00);

    foreach (directed_rows[row]) begin
      if (directed_rows[row].op == ROW_MODE) set_panel_mode(directed_rows[row].addr[0]);
      else send_command(directed_rows[row]);
    end

    // Random phases, alternating layouts
    for (phase = 0; phase < 4; phase++) begin
      set_panel_mode(phase_modes[phase]);
      for (i = 0; i < ITEMS_PER_RUN; i++) send_command(random_command());
    end
    s_axis_tvalid = 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
